/* hdl/atan2ra_pkg.sv */
// Shared types, constants and helper functions for the atan2 approximation unit.
`timescale 1ns / 1ps

package atan2ra_pkg;

    // Width of the angle field on the result channel.
    localparam int ANGLE_W = 16;

    // The 0.28 rational coefficient in Q16.
    localparam int K_W = 15;
    localparam logic [K_W-1:0] K_Q16 = 15'd18350;

    // pi in Q60.
    localparam logic [63:0] PI_Q60 = 64'h3243_F6A8_885A_308D;

    // Per-item flags that travel alongside the datapath.
    typedef struct packed {
        logic yneg;   // y is negative
        logic xneg;   // x is negative
        logic xzero;  // x magnitude is zero
        logic yzero;  // y magnitude is zero
        logic swap;   // |y| >= |x|, so the second form applies
    } t_flags;

    // pi scaled by 2^frac and rounded to nearest; pi/2 is pi_scaled(frac - 1).
    function automatic logic [63:0] pi_scaled(input int frac);
        logic [63:0] sum;
        sum = PI_Q60 + (64'd1 << (59 - frac));
        return sum >> (60 - frac);
    endfunction

endpackage

/* hdl/atan2ra_in_if.sv */
// Input channel interface carrying one (y, x) vector per transaction.
`timescale 1ns / 1ps

interface atan2ra_in_if #(
    parameter int IN_WIDTH = 16
) ();
    logic                       valid;
    logic                       ready;
    logic signed [IN_WIDTH-1:0] y_coord;
    logic signed [IN_WIDTH-1:0] x_coord;

    modport source (output valid, output y_coord, output x_coord, input ready);
    modport sink   (input valid, input y_coord, input x_coord, output ready);
endinterface

/* hdl/atan2ra_out_if.sv */
// Output channel interface carrying one angle per transaction.
`timescale 1ns / 1ps

interface atan2ra_out_if ();
    import atan2ra_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] angle;

    modport source (output valid, output angle, input ready);
    modport sink   (input valid, input angle, output ready);
endinterface

/* hdl/atan2ra_front.sv */
// Front end: magnitudes, octant flags, products and the quotient numerator and denominator.
`timescale 1ns / 1ps

module atan2ra_front #(
    parameter int IN_WIDTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic signed [IN_WIDTH-1:0] i_y_coord,
    input  logic signed [IN_WIDTH-1:0] i_x_coord,
    output logic                       o_valid,
    output atan2ra_pkg::t_flags        o_flags,
    output logic [2*IN_WIDTH+17:0]     o_num,
    output logic [2*IN_WIDTH+17:0]     o_den
);
    import atan2ra_pkg::*;

    localparam int W  = IN_WIDTH;
    localparam int PW = 2 * IN_WIDTH;
    localparam int DW = 2 * IN_WIDTH + 18;

    logic [W-1:0] w_yu;
    logic [W-1:0] w_xu;
    logic [W-1:0] w_ym;
    logic [W-1:0] w_xm;
    t_flags       w_flags;

    logic [3:0]        r_vld;
    logic [W-1:0]      r_s1_big;
    logic [W-1:0]      r_s1_small;
    t_flags            r_s1_flags;
    logic [PW-1:0]     r_s2_prod;
    logic [PW-1:0]     r_s2_big2;
    logic [PW-1:0]     r_s2_small2;
    t_flags            r_s2_flags;
    logic [DW-1:0]     r_s3_num;
    logic [PW-1:0]     r_s3_big2;
    logic [PW+K_W-1:0] r_s3_ks2;
    t_flags            r_s3_flags;
    logic [DW-1:0]     r_s4_num;
    logic [DW-1:0]     r_s4_den;
    t_flags            r_s4_flags;

    // The most negative input maps to 2^(W-1), which still fits unsigned.
    always_comb begin
        w_yu          = unsigned'(i_y_coord);
        w_xu          = unsigned'(i_x_coord);
        w_ym          = w_yu[W-1] ? (~w_yu + 1'b1) : w_yu;
        w_xm          = w_xu[W-1] ? (~w_xu + 1'b1) : w_xu;
        w_flags.yneg  = w_yu[W-1];
        w_flags.xneg  = w_xu[W-1];
        w_flags.xzero = (w_xm == '0);
        w_flags.yzero = (w_ym == '0);
        w_flags.swap  = !(w_ym < w_xm);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_big    <= w_flags.swap ? w_ym : w_xm;
            r_s1_small  <= w_flags.swap ? w_xm : w_ym;
            r_s1_flags  <= w_flags;

            r_s2_prod   <= r_s1_big * r_s1_small;
            r_s2_big2   <= r_s1_big * r_s1_big;
            r_s2_small2 <= r_s1_small * r_s1_small;
            r_s2_flags  <= r_s1_flags;

            r_s3_num    <= {2'b00, r_s2_prod, 16'h0000};
            r_s3_big2   <= r_s2_big2;
            r_s3_ks2    <= r_s2_small2 * K_Q16;
            r_s3_flags  <= r_s2_flags;

            r_s4_num    <= r_s3_num;
            r_s4_den    <= DW'({r_s3_big2, 16'h0000}) + DW'(r_s3_ks2);
            r_s4_flags  <= r_s3_flags;
        end
    end

    assign o_valid = r_vld[3];
    assign o_flags = r_s4_flags;
    assign o_num   = r_s4_num;
    assign o_den   = r_s4_den;

endmodule

/* hdl/atan2ra_div_cell.sv */
// One restoring division cell: shifts the remainder, trial-subtracts and emits one quotient bit.
`timescale 1ns / 1ps

module atan2ra_div_cell #(
    parameter int DW = 50,
    parameter int QW = 14
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  atan2ra_pkg::t_flags i_flags,
    input  logic [DW-1:0]       i_rem,
    input  logic [DW-1:0]       i_den,
    input  logic [QW-1:0]       i_quo,
    output logic                o_valid,
    output atan2ra_pkg::t_flags o_flags,
    output logic [DW-1:0]       o_rem,
    output logic [DW-1:0]       o_den,
    output logic [QW-1:0]       o_quo
);
    import atan2ra_pkg::*;

    logic [DW-1:0] w_sh;
    logic          w_ge;
    logic [DW-1:0] n_rem;
    logic [QW-1:0] n_quo;

    logic          r_valid;
    t_flags        r_flags;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [QW-1:0] r_quo;

    // The remainder stays below the divisor, so the shift never drops a set bit.
    always_comb begin
        w_sh  = {i_rem[DW-2:0], 1'b0};
        w_ge  = (w_sh >= i_den);
        n_rem = w_ge ? (w_sh - i_den) : w_sh;
        n_quo = {i_quo[QW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flags <= i_flags;
            r_rem   <= n_rem;
            r_den   <= i_den;
            r_quo   <= n_quo;
        end
    end

    assign o_valid = r_valid;
    assign o_flags = r_flags;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_quo   = r_quo;

endmodule

/* hdl/atan2ra_finish.sv */
// Final stage: rounds the quotient, applies its sign and folds the angle into its quadrant.
`timescale 1ns / 1ps

module atan2ra_finish #(
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  atan2ra_pkg::t_flags                  i_flags,
    input  logic [ANGLE_FRAC_BITS:0]             i_quo,
    output logic                                 o_valid,
    output logic signed [atan2ra_pkg::ANGLE_W-1:0] o_angle,
    output logic signed [ANGLE_FRAC_BITS+3:0]    o_fix
);
    import atan2ra_pkg::*;

    localparam int F  = ANGLE_FRAC_BITS;
    localparam int QW = ANGLE_FRAC_BITS + 1;
    localparam int AW = ANGLE_FRAC_BITS + 4;
    localparam int EW = (AW > ANGLE_W) ? AW : ANGLE_W;
    localparam logic [63:0] PI_RND    = pi_scaled(F);
    localparam logic [63:0] PIBY2_RND = pi_scaled(F - 1);
    localparam logic signed [AW-1:0] PI_FIX    = AW'(PI_RND);
    localparam logic signed [AW-1:0] PIBY2_FIX = AW'(PIBY2_RND);

    logic [QW:0]            w_rnd;
    logic signed [AW-1:0]   w_q;
    logic signed [AW-1:0]   w_qs;
    logic signed [AW-1:0]   n_fix;
    logic signed [EW-1:0]   w_ext;

    logic                   r_valid;
    logic signed [AW-1:0]   r_fix;

    // The cell chain produced one guard bit; round half away from zero on the magnitude.
    always_comb begin
        w_rnd = {1'b0, i_quo} + 1'b1;
        w_q   = signed'(AW'(w_rnd[QW:1]));
        w_qs  = (i_flags.xneg ^ i_flags.yneg) ? -w_q : w_q;
        if (i_flags.xzero) begin
            if (i_flags.yzero) begin
                n_fix = '0;
            end else begin
                n_fix = i_flags.yneg ? -PIBY2_FIX : PIBY2_FIX;
            end
        end else if (!i_flags.swap) begin
            n_fix = w_qs;
            if (i_flags.xneg) begin
                n_fix = i_flags.yneg ? (w_qs - PI_FIX) : (w_qs + PI_FIX);
            end
        end else begin
            n_fix = PIBY2_FIX - w_qs;
            if (i_flags.yneg) begin
                n_fix = PIBY2_FIX - w_qs - PI_FIX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fix <= n_fix;
        end
    end

    assign w_ext   = EW'(r_fix);
    assign o_valid = r_valid;
    assign o_angle = signed'(w_ext[ANGLE_W-1:0]);
    assign o_fix   = r_fix;

endmodule

/* hdl/atan2_rational_approx_unit.sv */
// Top level of the pipelined atan2 approximation unit.
`timescale 1ns / 1ps

// This unit takes a signed (y, x) vector on i_vec and returns an approximate atan2 angle on
// o_ang, in radians with ANGLE_FRAC_BITS fractional bits, using the 0.28 rational form of the
// arctangent with the division cleared, so that every quotient is below one. It accepts one
// transaction per clock cycle for as long as the result side keeps taking them. The divider
// is a chain of ANGLE_FRAC_BITS + 1 identical restoring cells, each producing one quotient bit
// per cycle while the pipeline is not stalled and handing its remainder to the next cell. It
// sits behind four front-end stages (magnitude, the three products, the scaled coefficient
// product, the denominator add) and one final stage that rounds and places the angle in its
// quadrant. The whole pipeline advances together; when a result is held on o_ang because the
// sink is not ready, the pipeline and i_vec.ready stall with it, and nothing is lost or
// repeated. An x of zero gives +pi/2, 0 or -pi/2 by the sign of y, and the most negative
// input is used at its exact magnitude. Results are taken modulo 2^16 on the angle field,
// which only matters for fraction widths above 13.
module atan2_rational_approx_unit #(
    parameter int IN_WIDTH        = 16,
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    atan2ra_in_if.sink     i_vec,
    atan2ra_out_if.source  o_ang
);
    import atan2ra_pkg::*;

    localparam int DW = 2 * IN_WIDTH + 18;
    localparam int QW = ANGLE_FRAC_BITS + 1;
    localparam int NC = ANGLE_FRAC_BITS + 1;
    localparam int AW = ANGLE_FRAC_BITS + 4;
    localparam logic signed [AW-1:0] PI_FIX = AW'(pi_scaled(ANGLE_FRAC_BITS));

    // The pipeline moves forward whenever the output register is empty or being drained.
    logic w_en;

    logic [NC:0]   w_vld;
    t_flags        w_flags [0:NC];
    logic [DW-1:0] w_rem   [0:NC];
    logic [DW-1:0] w_den   [0:NC];
    logic [QW-1:0] w_quo   [0:NC];

    logic signed [AW-1:0] w_fix;

    assign w_en        = !o_ang.valid || o_ang.ready;
    assign i_vec.ready = w_en;

    // Front end: the numerator enters the divider chain as the initial remainder.
    atan2ra_front #(
        .IN_WIDTH (IN_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (i_vec.valid),
        .i_y_coord (i_vec.y_coord),
        .i_x_coord (i_vec.x_coord),
        .o_valid   (w_vld[0]),
        .o_flags   (w_flags[0]),
        .o_num     (w_rem[0]),
        .o_den     (w_den[0])
    );

    assign w_quo[0] = '0;

    // Divider chain: cell i settles the i-th quotient bit counted from the most significant end.
    for (genvar gi = 0; gi < NC; gi++) begin : g_cell
        atan2ra_div_cell #(
            .DW (DW),
            .QW (QW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_vld[gi]),
            .i_flags (w_flags[gi]),
            .i_rem   (w_rem[gi]),
            .i_den   (w_den[gi]),
            .i_quo   (w_quo[gi]),
            .o_valid (w_vld[gi+1]),
            .o_flags (w_flags[gi+1]),
            .o_rem   (w_rem[gi+1]),
            .o_den   (w_den[gi+1]),
            .o_quo   (w_quo[gi+1])
        );
    end

    // Final stage holds the output register that o_ang presents.
    atan2ra_finish #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_vld[NC]),
        .i_flags (w_flags[NC]),
        .i_quo   (w_quo[NC]),
        .o_valid (o_ang.valid),
        .o_angle (o_ang.angle),
        .o_fix   (w_fix)
    );

    // The last cell must leave a remainder below a nonzero divisor, or a quotient bit was lost.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vld[NC] && (w_den[NC] != '0)) |-> (w_rem[NC] < w_den[NC]))
        else $error("divider remainder not below divisor at end of cell chain");

    // Every delivered angle lies within -pi .. +pi before it is narrowed to the port.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ang.valid |-> ((w_fix <= PI_FIX) && (w_fix >= -PI_FIX)))
        else $error("angle outside -pi .. +pi");

    // While the output is stalled, no transaction may move, appear or vanish in the pipeline.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(w_vld) && $stable(o_ang.valid)))
        else $error("pipeline occupancy changed during a stall");

endmodule
